// ===== hdl/sabd_pkg.sv =====
// Shared constants, types and sigmoid table for the SSD anchor box decoder.
`timescale 1ns / 1ps
`default_nettype none
package sabd_pkg;

   localparam int MAX_LAYERS          = 4;
   localparam int SIGMOID_TABLE_DEPTH = 256;
   localparam int STRIDE_SLOTS        = 4;
   localparam int SIG_IDX_W           = $clog2(SIGMOID_TABLE_DEPTH);
   localparam int LAYER_IDX_W         = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int LAYER_CNT_W         = $clog2(MAX_LAYERS + 1);
   localparam int APC_W               = $clog2(8 * MAX_LAYERS + 1);
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 32;
   localparam int DIV_NUM_W           = 28;
   localparam int DIV_DEN_W           = 12;
   localparam int DIV_STEPS           = DIV_NUM_W / 2;
   localparam int DIV_CNT_W           = $clog2(DIV_STEPS);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INPUT_WIDTH,
      CSR_INPUT_HEIGHT,
      CSR_SCORE_THRESHOLD,
      CSR_ANCHOR_OFFSET_X,
      CSR_ANCHOR_OFFSET_Y,
      CSR_LAYER_STRIDES,
      CSR_ANCHORS_PER_LAYER,
      CSR_REDUCE_LOWEST_LAYER
   } csr_index_type;

   typedef enum logic [2:0] {
      DOP_FMW,
      DOP_FMH,
      DOP_AX,
      DOP_AY,
      DOP_CX,
      DOP_CY,
      DOP_HW,
      DOP_HH
   } div_op_type;

   typedef struct packed {
      logic       accept;
      logic       start_item;
      logic       check;
      logic       div_start;
      div_op_type div_op;
      logic       div_capture;
      logic       finish;
   } sabd_cmd_type;

   typedef struct packed {
      logic nl_zero;
      logic stale;
      logic div_done;
      logic out_free;
   } sabd_status_type;

   typedef logic [SIGMOID_TABLE_DEPTH-1:0][15:0] sig_tab_type;

   // sigmoid(8*i/DEPTH) in Q0.16, exp(-x) by series on x/16 then squared four times
   function automatic sig_tab_type build_sig_tab();
      sig_tab_type          t;
      logic        [63:0]   yq;
      logic        [63:0]   term;
      logic        [63:0]   e;
      logic        [63:0]   r;
      logic        [63:0]   num;
      logic        [63:0]   q;
      logic        [63:0]   rm;
      longint               sum;
      for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin
         yq   = ((64'(i) << 30) + 64'(SIGMOID_TABLE_DEPTH)) / (2 * SIGMOID_TABLE_DEPTH);
         term = 64'd1 << 30;
         sum  = longint'(term);
         for (int n = 1; n <= 10; n++) begin
            term = (term * yq) >> 30;
            case (n)
               2:  term = term / 2;
               3:  term = term / 3;
               4:  term = term / 4;
               5:  term = term / 5;
               6:  term = term / 6;
               7:  term = term / 7;
               8:  term = term / 8;
               9:  term = term / 9;
               10: term = term / 10;
               default: term = term;
            endcase
            if ((n % 2) == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         e = (sum < 0) ? 64'd0 : 64'(sum);
         for (int k = 0; k < 4; k++) begin
            e = (e * e + (64'd1 << 29)) >> 30;
         end
         r   = (64'd1 << 30) + e;
         num = (64'd1 << 46) + (r >> 1);
         q   = 64'd0;
         rm  = 64'd0;
         for (int b = 47; b >= 0; b--) begin
            rm = (rm << 1) | 64'(num[b]);
            if (rm >= r) begin
               rm   = rm - r;
               q[b] = 1'b1;
            end
         end
         t[i] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
      end
      return t;
   endfunction

   localparam sig_tab_type SIG_TAB = build_sig_tab();

endpackage
`default_nettype wire

// ===== hdl/sabd_div.sv =====
// Shared restoring divider, two quotient bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sabd_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [sabd_pkg::DIV_NUM_W-1:0] num,
   input  logic [sabd_pkg::DIV_DEN_W-1:0] den,
   output logic [sabd_pkg::DIV_NUM_W-1:0] quot,
   output logic                           rem_nz,
   output logic                           done,
   output logic                           busy
);
   import sabd_pkg::*;

   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_DEN_W:0]   trial;
   logic                 last_step;

   assign last_step = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      trial  = '0;
      for (int k = 0; k < 2; k++) begin
         trial  = {rem_in, quo_in[DIV_NUM_W-1]};
         quo_in = {quo_in[DIV_NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial     = trial - {1'b0, den_ff};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[DIV_DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last_step;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last_step) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quot   = quo_ff;
   assign rem_nz = (rem_ff != '0);
   assign done   = done_ff;
   assign busy   = busy_ff;

endmodule
`default_nettype wire

// ===== hdl/sabd_ctrl.sv =====
// Sequencer: accepts a word, steps the divider through its operations, loads the result.
`timescale 1ns / 1ps
`default_nettype none
module sabd_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sabd_pkg::sabd_status_type status,
   output sabd_pkg::sabd_cmd_type    cmd
);
   import sabd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_CHECK,
      ST_FINISH
   } state_type;

   state_type  state_ff, state_in;
   div_op_type op_ff, op_in;
   logic       wait_ff, wait_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      wait_in  = wait_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            op_in    = status.nl_zero ? DOP_CX : DOP_FMW;
            wait_in  = 1'b0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!wait_ff) begin
               wait_in = 1'b1;
            end else if (status.div_done) begin
               wait_in = 1'b0;
               case (op_ff)
                  DOP_FMW: op_in = DOP_FMH;
                  DOP_FMH: state_in = ST_CHECK;
                  DOP_AX:  op_in = DOP_AY;
                  DOP_AY:  op_in = DOP_CX;
                  DOP_CX:  op_in = DOP_CY;
                  DOP_CY:  op_in = DOP_HW;
                  DOP_HW:  op_in = DOP_HH;
                  DOP_HH:  state_in = ST_FINISH;
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_CHECK: begin
            op_in    = status.stale ? DOP_FMW : DOP_AX;
            wait_in  = 1'b0;
            state_in = ST_DIV;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= DOP_FMW;
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         wait_ff  <= wait_in;
      end
   end

   always_comb begin
      cmd             = '0;
      cmd.accept      = (state_ff == ST_IDLE) && req_valid;
      cmd.start_item  = (state_ff == ST_START);
      cmd.check       = (state_ff == ST_CHECK);
      cmd.div_start   = (state_ff == ST_DIV) && !wait_ff;
      cmd.div_op      = op_ff;
      cmd.div_capture = (state_ff == ST_DIV) && wait_ff && status.div_done;
      cmd.finish      = (state_ff == ST_FINISH) && status.out_free;
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

// ===== hdl/sabd_dpath.sv =====
// Datapath: registers, anchor grid counters, operand select, score lookup, result word.
`timescale 1ns / 1ps
`default_nettype none
module sabd_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  sabd_pkg::sabd_cmd_type           cmd,
   output sabd_pkg::sabd_status_type        status,
   input  logic                             csr_we,
   input  logic [sabd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sabd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic signed [15:0]               req_score_logit,
   input  logic signed [15:0]               req_center_dx,
   input  logic signed [15:0]               req_center_dy,
   input  logic signed [15:0]               req_box_width,
   input  logic signed [15:0]               req_box_height,
   input  logic                             req_frame_start,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_kept,
   output logic [15:0]                      rsp_anchor_index,
   output logic [15:0]                      rsp_score,
   output logic signed [17:0]               rsp_x_min,
   output logic signed [17:0]               rsp_y_min,
   output logic signed [17:0]               rsp_x_max,
   output logic signed [17:0]               rsp_y_max,
   output logic                             rsp_frame_last
);
   import sabd_pkg::*;

   localparam int IDX_PROD_W = 16 + SIG_IDX_W + 1;

   // configuration
   logic [10:0] in_w_ff, in_h_ff;
   logic [15:0] thr_ff, offx_ff, offy_ff;
   logic [31:0] strides_ff;
   logic [3:0]  apl_ff;
   logic        reduce_ff;

   // latched word
   logic signed [15:0] logit_ff, dx_ff, dy_ff, bw_ff, bh_ff;
   logic               fs_ff;

   // grid state
   logic [15:0]            count_ff;
   logic [LAYER_IDX_W-1:0] gfl_ff;
   logic [9:0]             col_ff, row_ff;
   logic [5:0]             ain_ff;

   // intermediate results
   logic [10:0]        fmw_ff, fmh_ff;
   logic [15:0]        ax_ff, ay_ff;
   logic signed [27:0] cx_ff, cy_ff, hw_ff, hh_ff;

   // result word
   logic               out_valid_ff;
   logic               kept_ff, last_ff;
   logic [15:0]        index_ff, score_ff;
   logic signed [17:0] xmin_ff, ymin_ff, xmax_ff, ymax_ff;

   logic [10:0]            w_eff, h_eff;
   logic [3:0]             apl_eff;
   logic [7:0]             stride [MAX_LAYERS];
   logic [LAYER_CNT_W-1:0] nl;
   logic                   run;
   logic [7:0]             g_stride;
   logic                   g_run;
   logic [LAYER_CNT_W-1:0] grp_end;
   logic [APC_W-1:0]       apc;
   logic                   nl_zero, stale, restart_start;
   logic                   out_free;

   logic [DIV_NUM_W-1:0] div_num, div_quot;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_rem_nz, div_done, div_busy;
   logic signed [27:0]   snum;
   logic                 sneg;
   logic [27:0]          sfix, qa;

   logic [15:0]           abs_logit;
   logic [IDX_PROD_W-1:0] idx_prod, idx_full;
   logic [15:0]           pos;
   logic [16:0]           neg_score;
   logic [15:0]           score;

   logic [6:0]  ain_p1;
   logic [10:0] col_p1, row_p1;
   logic        wrap_cell, wrap_col, wrap_row, frame_last_n;

   function automatic logic signed [17:0] sat18(input logic signed [27:0] v);
      logic signed [17:0] r;
      if (v > 28'sd131071) begin
         r = 18'sh1FFFF;
      end else if (v < -28'sd131072) begin
         r = 18'sh20000;
      end else begin
         r = v[17:0];
      end
      return r;
   endfunction

   // effective configuration and layer list
   always_comb begin
      w_eff   = (in_w_ff == '0) ? 11'd1 : ((in_w_ff > 11'd1024) ? 11'd1024 : in_w_ff);
      h_eff   = (in_h_ff == '0) ? 11'd1 : ((in_h_ff > 11'd1024) ? 11'd1024 : in_h_ff);
      apl_eff = (apl_ff == '0) ? 4'd1 : ((apl_ff > 4'd8) ? 4'd8 : apl_ff);
      for (int i = 0; i < MAX_LAYERS; i++) begin
         stride[i] = (i < STRIDE_SLOTS) ? strides_ff[8*i +: 8] : 8'd0;
      end
      nl  = '0;
      run = 1'b1;
      for (int i = 0; i < MAX_LAYERS; i++) begin
         if (run && stride[i] != 8'd0) begin
            nl = LAYER_CNT_W'(i + 1);
         end else begin
            run = 1'b0;
         end
      end
   end

   // current group: contiguous layers of equal stride from the group's first layer gfl_ff
   always_comb begin
      g_stride = stride[gfl_ff];
      grp_end  = LAYER_CNT_W'(gfl_ff);
      apc      = '0;
      g_run    = 1'b1;
      for (int e = 0; e < MAX_LAYERS; e++) begin
         if (LAYER_CNT_W'(e) >= LAYER_CNT_W'(gfl_ff)) begin
            if (g_run && LAYER_CNT_W'(e) < nl && stride[e] == g_stride) begin
               apc     = apc + ((e == 0 && reduce_ff) ? APC_W'(3) : APC_W'(apl_eff));
               grp_end = LAYER_CNT_W'(e + 1);
            end else begin
               g_run = 1'b0;
            end
         end
      end
   end

   assign nl_zero       = (nl == '0);
   assign restart_start = fs_ff || nl_zero || (LAYER_CNT_W'(gfl_ff) >= nl);
   assign stale         = ({1'b0, col_ff} >= fmw_ff) || ({1'b0, row_ff} >= fmh_ff)
                          || (APC_W'(ain_ff) >= apc);

   // divider operands
   always_comb begin
      snum = '0;
      case (cmd.div_op)
         DOP_CX:  snum = {{2{dx_ff[15]}}, dx_ff, 10'b0} + {17'b0, w_eff};
         DOP_CY:  snum = {{2{dy_ff[15]}}, dy_ff, 10'b0} + {17'b0, h_eff};
         DOP_HW:  snum = {{3{bw_ff[15]}}, bw_ff, 9'b0} + {17'b0, w_eff};
         DOP_HH:  snum = {{3{bh_ff[15]}}, bh_ff, 9'b0} + {17'b0, h_eff};
         default: snum = '0;
      endcase
      sneg = snum[27];
      case (cmd.div_op)
         DOP_FMW: begin
            div_num = {17'b0, w_eff} + {20'b0, g_stride} - 28'd1;
            div_den = {4'b0, g_stride};
         end
         DOP_FMH: begin
            div_num = {17'b0, h_eff} + {20'b0, g_stride} - 28'd1;
            div_den = {4'b0, g_stride};
         end
         DOP_AX: begin
            div_num = {2'b0, col_ff, 16'b0} + {12'b0, offx_ff} + {17'b0, fmw_ff};
            div_den = {fmw_ff, 1'b0};
         end
         DOP_AY: begin
            div_num = {2'b0, row_ff, 16'b0} + {12'b0, offy_ff} + {17'b0, fmh_ff};
            div_den = {fmh_ff, 1'b0};
         end
         DOP_CX, DOP_HW: begin
            div_num = sneg ? 28'(-snum) : 28'(snum);
            div_den = {w_eff, 1'b0};
         end
         DOP_CY, DOP_HH: begin
            div_num = sneg ? 28'(-snum) : 28'(snum);
            div_den = {h_eff, 1'b0};
         end
         default: begin
            div_num = '0;
            div_den = {11'b0, 1'b1};
         end
      endcase
      qa   = div_quot + 28'(div_rem_nz);
      sfix = sneg ? 28'(-qa) : div_quot;
   end

   sabd_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .num    (div_num),
      .den    (div_den),
      .quot   (div_quot),
      .rem_nz (div_rem_nz),
      .done   (div_done),
      .busy   (div_busy)
   );

   // sigmoid score
   always_comb begin
      abs_logit = logit_ff[15] ? 16'(-logit_ff) : 16'(logit_ff);
      idx_prod  = IDX_PROD_W'(abs_logit) * IDX_PROD_W'(SIGMOID_TABLE_DEPTH);
      idx_full  = idx_prod >> 13;
      pos       = (idx_full >= IDX_PROD_W'(SIGMOID_TABLE_DEPTH)) ? 16'hFFFF
                  : SIG_TAB[idx_full[SIG_IDX_W-1:0]];
      neg_score = 17'h10000 - {1'b0, pos};
      if (!logit_ff[15]) begin
         score = pos;
      end else if (neg_score[16]) begin
         score = 16'hFFFF;
      end else begin
         score = neg_score[15:0];
      end
   end

   // grid advance
   always_comb begin
      ain_p1       = {1'b0, ain_ff} + 7'd1;
      col_p1       = {1'b0, col_ff} + 11'd1;
      row_p1       = {1'b0, row_ff} + 11'd1;
      wrap_cell    = (ain_p1 >= 7'(apc));
      wrap_col     = (col_p1 >= fmw_ff);
      wrap_row     = (row_p1 >= fmh_ff);
      frame_last_n = nl_zero || (wrap_cell && wrap_col && wrap_row && (grp_end >= nl));
   end

   assign out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_w_ff      <= 11'd128;
         in_h_ff      <= 11'd128;
         thr_ff       <= 16'd49152;
         offx_ff      <= 16'd32768;
         offy_ff      <= 16'd32768;
         strides_ff   <= 32'd269488136;
         apl_ff       <= 4'd2;
         reduce_ff    <= 1'b0;
         count_ff     <= '0;
         gfl_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         ain_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_INPUT_WIDTH:         in_w_ff    <= csr_wdata[10:0];
               CSR_INPUT_HEIGHT:        in_h_ff    <= csr_wdata[10:0];
               CSR_SCORE_THRESHOLD:     thr_ff     <= csr_wdata[15:0];
               CSR_ANCHOR_OFFSET_X:     offx_ff    <= csr_wdata[15:0];
               CSR_ANCHOR_OFFSET_Y:     offy_ff    <= csr_wdata[15:0];
               CSR_LAYER_STRIDES:       strides_ff <= csr_wdata[31:0];
               CSR_ANCHORS_PER_LAYER:   apl_ff     <= csr_wdata[3:0];
               CSR_REDUCE_LOWEST_LAYER: reduce_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         if ((cmd.start_item && restart_start) || (cmd.check && stale)) begin
            count_ff <= '0;
            gfl_ff   <= '0;
            col_ff   <= '0;
            row_ff   <= '0;
            ain_ff   <= '0;
         end else if (cmd.finish && !nl_zero) begin
            if (frame_last_n) begin
               count_ff <= '0;
               gfl_ff   <= '0;
               col_ff   <= '0;
               row_ff   <= '0;
               ain_ff   <= '0;
            end else begin
               count_ff <= count_ff + 16'd1;
               if (wrap_cell) begin
                  ain_ff <= '0;
                  if (wrap_col) begin
                     col_ff <= '0;
                     if (wrap_row) begin
                        row_ff <= '0;
                        gfl_ff <= grp_end[LAYER_IDX_W-1:0];
                     end else begin
                        row_ff <= row_p1[9:0];
                     end
                  end else begin
                     col_ff <= col_p1[9:0];
                  end
               end else begin
                  ain_ff <= ain_p1[5:0];
               end
            end
         end
         if (cmd.finish) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         logit_ff <= req_score_logit;
         dx_ff    <= req_center_dx;
         dy_ff    <= req_center_dy;
         bw_ff    <= req_box_width;
         bh_ff    <= req_box_height;
         fs_ff    <= req_frame_start;
      end
      if (cmd.start_item && nl_zero) begin
         ax_ff <= '0;
         ay_ff <= '0;
      end
      if (cmd.div_capture) begin
         case (cmd.div_op)
            DOP_FMW: fmw_ff <= div_quot[10:0];
            DOP_FMH: fmh_ff <= div_quot[10:0];
            DOP_AX:  ax_ff  <= div_quot[15:0];
            DOP_AY:  ay_ff  <= div_quot[15:0];
            DOP_CX:  cx_ff  <= {12'b0, ax_ff} + sfix;
            DOP_CY:  cy_ff  <= {12'b0, ay_ff} + sfix;
            DOP_HW:  hw_ff  <= sfix;
            DOP_HH:  hh_ff  <= sfix;
            default: ;
         endcase
      end
      if (cmd.finish) begin
         kept_ff  <= (score > thr_ff);
         index_ff <= count_ff;
         score_ff <= score;
         xmin_ff  <= sat18(cx_ff - hw_ff);
         ymin_ff  <= sat18(cy_ff - hh_ff);
         xmax_ff  <= sat18(cx_ff + hw_ff);
         ymax_ff  <= sat18(cy_ff + hh_ff);
         last_ff  <= frame_last_n;
      end
   end

   always_comb begin
      status          = '0;
      status.nl_zero  = nl_zero;
      status.stale    = stale;
      status.div_done = div_done;
      status.out_free = out_free;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kept         = kept_ff;
   assign rsp_anchor_index = index_ff;
   assign rsp_score        = score_ff;
   assign rsp_x_min        = xmin_ff;
   assign rsp_y_min        = ymin_ff;
   assign rsp_x_max        = xmax_ff;
   assign rsp_y_max        = ymax_ff;
   assign rsp_frame_last   = last_ff;

`ifndef SYNTHESIS
   a_div_start_free: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider started while busy");
   a_finish_in_grid: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && !nl_zero) |-> !stale)
      else $error("finishing a word with counters outside the grid");
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && frame_last_n) |=>
      (count_ff == '0 && col_ff == '0 && row_ff == '0 && ain_ff == '0 && gfl_ff == '0))
      else $error("grid counters not cleared after last anchor");
`endif

endmodule
`default_nettype wire

// ===== hdl/ssd_anchor_box_decoder.sv =====
// Top level of the SSD anchor box decoder.
// Usage:
//   One request word per anchor (score logit, box offsets, frame_start) enters on
//   req_valid/req_stall; one result word per request leaves on rsp_valid/rsp_stall
//   with kept flag, anchor index, sigmoid score, normalized corners, frame_last.
//   A word is taken at a clock edge with valid high and stall low.
//   Each word runs through one shared divider (two quotient bits per cycle):
//   feature map width and height, anchor center x and y, box center x and y,
//   half width and half height. The block takes a new word only after the
//   result of the last one is loaded; an empty stride list skips the grid
//   divisions, and counters found outside the grid cost two extra divisions
//   and a check.
//   The result sits in an output register, so while the receiver stalls the
//   block still takes and works on the next word; it waits only to load the
//   next result. Registers are written through csr_we/csr_index/csr_wdata;
//   the user must write them only while the block is idle; the block does not enforce it.
//   Synchronous reset loads the register defaults, clears the anchor counters
//   and drops rsp_valid.
`timescale 1ns / 1ps
`default_nettype none
module ssd_anchor_box_decoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [sabd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sabd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [15:0]               req_score_logit,
   input  logic signed [15:0]               req_center_dx,
   input  logic signed [15:0]               req_center_dy,
   input  logic signed [15:0]               req_box_width,
   input  logic signed [15:0]               req_box_height,
   input  logic                             req_frame_start,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_kept,
   output logic [15:0]                      rsp_anchor_index,
   output logic [15:0]                      rsp_score,
   output logic signed [17:0]               rsp_x_min,
   output logic signed [17:0]               rsp_y_min,
   output logic signed [17:0]               rsp_x_max,
   output logic signed [17:0]               rsp_y_max,
   output logic                             rsp_frame_last
);
   import sabd_pkg::*;

   sabd_cmd_type    cmd;
   sabd_status_type status;

   sabd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sabd_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_score_logit  (req_score_logit),
      .req_center_dx    (req_center_dx),
      .req_center_dy    (req_center_dy),
      .req_box_width    (req_box_width),
      .req_box_height   (req_box_height),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kept         (rsp_kept),
      .rsp_anchor_index (rsp_anchor_index),
      .rsp_score        (rsp_score),
      .rsp_x_min        (rsp_x_min),
      .rsp_y_min        (rsp_y_min),
      .rsp_x_max        (rsp_x_max),
      .rsp_y_max        (rsp_y_max),
      .rsp_frame_last   (rsp_frame_last)
   );

endmodule
`default_nettype wire

// ===== bench/sabd_checker.sv =====
// Checker for the SSD anchor box decoder: tracks registers, predicts result words and compares.
`timescale 1ns / 1ps
module sabd_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [sabd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sabd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic signed [15:0]               req_score_logit,
   input  logic signed [15:0]               req_center_dx,
   input  logic signed [15:0]               req_center_dy,
   input  logic signed [15:0]               req_box_width,
   input  logic signed [15:0]               req_box_height,
   input  logic                             req_frame_start,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic                             rsp_kept,
   input  logic [15:0]                      rsp_anchor_index,
   input  logic [15:0]                      rsp_score,
   input  logic signed [17:0]               rsp_x_min,
   input  logic signed [17:0]               rsp_y_min,
   input  logic signed [17:0]               rsp_x_max,
   input  logic signed [17:0]               rsp_y_max,
   input  logic                             rsp_frame_last,
   output int                               fail_count,
   output int                               pending,
   output int                               frames_seen
);
   import sabd_pkg::*;

   localparam int DEPTH  = SIGMOID_TABLE_DEPTH;
   localparam int LAYERS = MAX_LAYERS;

   typedef struct {
      logic        kept;
      logic [15:0] index;
      logic [15:0] score;
      logic [17:0] x_min;
      logic [17:0] y_min;
      logic [17:0] x_max;
      logic [17:0] y_max;
      logic        last;
   } box_word_type;

   box_word_type box_q[$];
   int unsigned sigmoid_lut[DEPTH];

   logic [10:0] cfg_w, cfg_h;
   logic [15:0] cfg_thr, cfg_offx, cfg_offy;
   logic [31:0] cfg_strides;
   logic [3:0]  cfg_apl;
   logic        cfg_reduce;

   int unsigned cnt_anchor, cnt_group, cnt_col, cnt_row, cnt_sub;

   function automatic void fill_sigmoid();
      longint unsigned yq, term, e, r;
      longint          sum;
      for (int i = 0; i < DEPTH; i++) begin
         yq   = ((longint'(i) << 30) + DEPTH) / (2 * DEPTH);
         term = 64'd1 << 30;
         sum  = longint'(term);
         for (int n = 1; n <= 10; n++) begin
            term = ((term * yq) >> 30) / n;
            if (n % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
         end
         e = (sum < 0) ? 0 : sum;
         for (int k = 0; k < 4; k++) e = (e * e + (64'd1 << 29)) >> 30;
         r = (64'd1 << 30) + e;
         r = ((64'd1 << 46) + r / 2) / r;
         sigmoid_lut[i] = (r > 65535) ? 65535 : int'(r);
      end
   endfunction

   function automatic longint floor_q(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   function automatic longint round_q(longint n, longint d);
      return floor_q(2 * n + d, 2 * d);
   endfunction

   function automatic logic [17:0] clip18(longint v);
      if (v > 131071) return 18'h1FFFF;
      if (v < -131072) return 18'h20000;
      return v[17:0];
   endfunction

   function automatic int unsigned stride(int unsigned i);
      if (i >= LAYERS || i >= 4) return 0;
      return cfg_strides[8*i +: 8];
   endfunction

   function automatic int unsigned size_clip(logic [10:0] v);
      if (v == 0) return 1;
      return (v > 1024) ? 1024 : v;
   endfunction

   function automatic void group_shape(int unsigned g, int unsigned nl, output int unsigned e,
                                       output int unsigned apc, output int unsigned fmw,
                                       output int unsigned fmh);
      int unsigned s, apl;
      s   = stride(g);
      apl = (cfg_apl == 0) ? 1 : ((cfg_apl > 8) ? 8 : cfg_apl);
      e   = g;
      apc = 0;
      while (e < nl && stride(e) == s) begin
         apc += (e == 0 && cfg_reduce) ? 3 : apl;
         e++;
      end
      fmw = (size_clip(cfg_w) + s - 1) / s;
      fmh = (size_clip(cfg_h) + s - 1) / s;
   endfunction

   function automatic void grid_restart();
      cnt_anchor = 0;
      cnt_group  = 0;
      cnt_col    = 0;
      cnt_row    = 0;
      cnt_sub    = 0;
   endfunction

   function automatic box_word_type decode_box(logic signed [15:0] logit,
                                               logic signed [15:0] dx,
                                               logic signed [15:0] dy,
                                               logic signed [15:0] bw,
                                               logic signed [15:0] bh, logic fs);
      box_word_type o;
      longint       w, h, ax, ay, cx, cy, hw, hh, mag;
      int unsigned  nl, e, apc, fmw, fmh, idx, pos, sc;
      logic         last;
      logic [15:0]  index;
      w    = size_clip(cfg_w);
      h    = size_clip(cfg_h);
      ax   = 0;
      ay   = 0;
      last = 0;
      e    = 0;
      apc  = 0;
      fmw  = 1;
      fmh  = 1;
      nl   = 0;
      while (nl < LAYERS && stride(nl) != 0) nl++;
      if (fs) grid_restart();
      if (nl == 0) begin
         grid_restart();
         last  = 1;
         index = 0;
      end else begin
         if (cnt_group >= nl) grid_restart();
         group_shape(cnt_group, nl, e, apc, fmw, fmh);
         if (cnt_col >= fmw || cnt_row >= fmh || cnt_sub >= apc) begin
            grid_restart();
            group_shape(0, nl, e, apc, fmw, fmh);
         end
         ax = ((longint'(cnt_col) << 16) + cfg_offx + fmw) / (2 * longint'(fmw));
         ay = ((longint'(cnt_row) << 16) + cfg_offy + fmh) / (2 * longint'(fmh));
         index = cnt_anchor[15:0];
         cnt_sub++;
         if (cnt_sub >= apc) begin
            cnt_sub = 0;
            cnt_col++;
            if (cnt_col >= fmw) begin
               cnt_col = 0;
               cnt_row++;
               if (cnt_row >= fmh) begin
                  cnt_row   = 0;
                  cnt_group = e;
                  if (cnt_group >= nl) last = 1;
               end
            end
         end
         if (last) grid_restart();
         else cnt_anchor = (cnt_anchor + 1) & 16'hFFFF;
      end
      mag = (logit < 0) ? -longint'(logit) : longint'(logit);
      idx = int'((mag * DEPTH) >> 13);
      pos = (idx >= DEPTH) ? 65535 : sigmoid_lut[idx];
      sc  = (logit < 0) ? 65536 - pos : pos;
      if (sc > 65535) sc = 65535;
      cx = ax + round_q(longint'(dx) * 512, w);
      cy = ay + round_q(longint'(dy) * 512, h);
      hw = round_q(longint'(bw) * 256, w);
      hh = round_q(longint'(bh) * 256, h);
      o.kept  = (sc > cfg_thr);
      o.index = index;
      o.score = sc[15:0];
      o.x_min = clip18(cx - hw);
      o.y_min = clip18(cy - hh);
      o.x_max = clip18(cx + hw);
      o.y_max = clip18(cy + hh);
      o.last  = last;
      return o;
   endfunction

   initial begin
      fill_sigmoid();
      fail_count  = 0;
      frames_seen = 0;
   end

   assign pending = box_q.size();

   always @(posedge clock) begin
      box_word_type want;
      if (reset) begin
         cfg_w       <= 11'd128;
         cfg_h       <= 11'd128;
         cfg_thr     <= 16'd49152;
         cfg_offx    <= 16'd32768;
         cfg_offy    <= 16'd32768;
         cfg_strides <= 32'd269488136;
         cfg_apl     <= 4'd2;
         cfg_reduce  <= 1'b0;
         grid_restart();
         box_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_INPUT_WIDTH:         cfg_w       <= csr_wdata[10:0];
               CSR_INPUT_HEIGHT:        cfg_h       <= csr_wdata[10:0];
               CSR_SCORE_THRESHOLD:     cfg_thr     <= csr_wdata[15:0];
               CSR_ANCHOR_OFFSET_X:     cfg_offx    <= csr_wdata[15:0];
               CSR_ANCHOR_OFFSET_Y:     cfg_offy    <= csr_wdata[15:0];
               CSR_LAYER_STRIDES:       cfg_strides <= csr_wdata;
               CSR_ANCHORS_PER_LAYER:   cfg_apl     <= csr_wdata[3:0];
               CSR_REDUCE_LOWEST_LAYER: cfg_reduce  <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            box_q.insert(box_q.size(),
                         decode_box(req_score_logit, req_center_dx, req_center_dy,
                                    req_box_width, req_box_height, req_frame_start));
         if (rsp_valid && !rsp_stall) begin
            if (box_q.size() == 0) begin
               $error("result word with nothing expected");
               fail_count++;
            end else begin
               want = box_q.pop_front();
               if (rsp_kept !== want.kept) begin
                  $error("kept: expected %0d actual %0d", want.kept, rsp_kept);
                  fail_count++;
               end
               if (rsp_anchor_index !== want.index) begin
                  $error("anchor_index: expected %0d actual %0d", want.index, rsp_anchor_index);
                  fail_count++;
               end
               if (rsp_score !== want.score) begin
                  $error("score: expected %0d actual %0d", want.score, rsp_score);
                  fail_count++;
               end
               if (rsp_x_min !== want.x_min) begin
                  $error("x_min: expected %0d actual %0d", $signed(want.x_min), rsp_x_min);
                  fail_count++;
               end
               if (rsp_y_min !== want.y_min) begin
                  $error("y_min: expected %0d actual %0d", $signed(want.y_min), rsp_y_min);
                  fail_count++;
               end
               if (rsp_x_max !== want.x_max) begin
                  $error("x_max: expected %0d actual %0d", $signed(want.x_max), rsp_x_max);
                  fail_count++;
               end
               if (rsp_y_max !== want.y_max) begin
                  $error("y_max: expected %0d actual %0d", $signed(want.y_max), rsp_y_max);
                  fail_count++;
               end
               if (rsp_frame_last !== want.last) begin
                  $error("frame_last: expected %0d actual %0d", want.last, rsp_frame_last);
                  fail_count++;
               end
               if (want.last) frames_seen++;
            end
         end
      end
   end
endmodule

// ===== bench/tb_ssd_anchor_box_decoder.sv =====
// Testbench top for the SSD anchor box decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_ssd_anchor_box_decoder;
   import sabd_pkg::*;

   localparam int PHASES      = 12;
   localparam int PHASE_WORDS = 155;
   localparam int DOG_LIMIT   = 6000;

   logic                   clock, reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_valid, req_stall, req_frame_start;
   logic signed [15:0]     req_score_logit, req_center_dx, req_center_dy;
   logic signed [15:0]     req_box_width, req_box_height;
   logic                   rsp_valid, rsp_stall, rsp_kept, rsp_frame_last;
   logic [15:0]            rsp_anchor_index, rsp_score;
   logic signed [17:0]     rsp_x_min, rsp_y_min, rsp_x_max, rsp_y_max;
   int                     fail_count, pending, frames_seen;
   int                     words_sent, settings_used, dog, cycle_no;
   logic                   calm;

   ssd_anchor_box_decoder dut (.*);

   sabd_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   assign calm = (cycle_no > 60000 && cycle_no < 95000);

   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         dog <= 0;
      end else if (dog >= DOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         dog <= dog + 1;
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = calm ? 1'b0 : ($urandom_range(99) < 8);
      end
   end

   task automatic csr_write(csr_index_type idx, logic [31:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic send_word(logic signed [15:0] lg, logic signed [15:0] dx,
                            logic signed [15:0] dy, logic signed [15:0] bw,
                            logic signed [15:0] bh, logic fs);
      logic taken;
      while (!calm && $urandom_range(99) < 8) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_score_logit = lg;
      req_center_dx   = dx;
      req_center_dy   = dy;
      req_box_width   = bw;
      req_box_height  = bh;
      req_frame_start = fs;
      do begin
         taken = !req_stall;
         @(negedge clock);
      end while (!taken);
      req_valid = 1'b0;
      words_sent++;
   endtask

   function automatic logic [15:0] pick_coord();
      if ($urandom_range(9) < 7) return 16'($signed($urandom_range(4000)) - 2000);
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_logit();
      if ($urandom_range(1)) return 16'($signed($urandom_range(16383)) - 8192);
      return 16'($urandom);
   endfunction

   function automatic logic [7:0] pick_stride();
      case ($urandom_range(5))
         0: return 8'd8;
         1: return 8'd16;
         2: return 8'd32;
         3: return 8'($urandom_range(1, 255));
         default: return 8'($urandom_range(4, 24));
      endcase
   endfunction

   task automatic set_phase(int p);
      logic [31:0] w, h, thr, ox, oy, st, apl, red;
      w   = $urandom_range(1, 96);
      h   = $urandom_range(1, 96);
      thr = $urandom_range(65535);
      ox  = $urandom_range(65535);
      oy  = $urandom_range(65535);
      st  = {pick_stride(), pick_stride(), pick_stride(), pick_stride()};
      if ($urandom_range(2) == 0) st[31:16] = 16'h0;
      if ($urandom_range(3) == 0) st[15:8] = st[7:0];
      apl = $urandom_range(15);
      red = $urandom_range(1);
      case (p)
         0: begin
            w = 1024; h = 1; thr = 0; ox = 0; oy = 0; st = 32'h1; apl = 1; red = 1;
         end
         1: begin
            w = 0; h = 2047; thr = 65535; ox = 65535; oy = 65535; st = 32'hFF; apl = 15;
         end
         2: st = 32'h0;
         3: st = 32'h00FF_FF00;
         4: begin
            w = 128; h = 128; thr = 49152; ox = 32768; oy = 32768; st = 32'h1010_1008;
            apl = 2; red = 0;
         end
         5: begin
            w = 2047; h = 1500; st = 32'hFFFF_FFFF; apl = 8; red = 0;
         end
         6: begin
            w = 1; h = 1; st = 32'h0101_0101; apl = 0; red = 1;
         end
         default: ;
      endcase
      csr_write(CSR_INPUT_WIDTH, w);
      csr_write(CSR_INPUT_HEIGHT, h);
      csr_write(CSR_SCORE_THRESHOLD, thr);
      csr_write(CSR_ANCHOR_OFFSET_X, ox);
      csr_write(CSR_ANCHOR_OFFSET_Y, oy);
      csr_write(CSR_LAYER_STRIDES, st);
      csr_write(CSR_ANCHORS_PER_LAYER, apl);
      csr_write(CSR_REDUCE_LOWEST_LAYER, red);
      settings_used++;
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   initial begin
      cycle_no        = 0;
      dog             = 0;
      words_sent      = 0;
      settings_used   = 1;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_valid       = 1'b0;
      req_score_logit = '0;
      req_center_dx   = '0;
      req_center_dy   = '0;
      req_box_width   = '0;
      req_box_height  = '0;
      req_frame_start = 1'b0;
      repeat (2) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: field extremes and mid-frame restarts
      send_word(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
      send_word(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
      send_word(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
      send_word(16'sd8191, 16'sd1, -16'sd1, 16'sd64, 16'sd64, 1'b0);
      send_word(16'sd8192, -16'sd1, 16'sd1, -16'sd64, -16'sd64, 1'b0);
      send_word(-16'sd8192, 16'sd100, 16'sd100, 16'sd640, 16'sd640, 1'b0);
      send_word(-16'sd8191, 16'sd0, 16'sd0, 16'sd8192, 16'sd8192, 1'b1);
      send_word(16'sd1, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 1'b0);
      send_word(-16'sd1, 16'sd32767, -16'sd32768, 16'sd0, 16'sd32767, 1'b0);
      send_word(16'sd2000, 16'sd3, 16'sd3, 16'sd3, 16'sd3, 1'b1);
      send_word(16'sd1500, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd0, 1'b0);
      for (int i = 0; i < 10; i++)
         send_word(pick_logit(), pick_coord(), pick_coord(), pick_coord(), pick_coord(), 1'b0);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         set_phase(p);
         for (int i = 0; i < PHASE_WORDS; i++)
            send_word(pick_logit(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                      $urandom_range(99) < 3);
         drain();
      end

      $display("Sent %0d request words under %0d register settings, %0d full grids seen.",
               words_sent, settings_used, frames_seen);
      $display("Settings spanned empty stride lists, clamped sizes and random small grids.");
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
